[src/pcs_pkg.sv]
// Shared types and constants for the packed 3-bit cell store.
// No dependencies; imported by packed_3bit_cell_store_top.
package pcs_pkg;

  // Default grid dimensions
  localparam int DEF_MAX_ROWS = 16;
  localparam int DEF_MAX_COLS = 16;

  // Payload field widths
  localparam int ROW_W   = 4;
  localparam int COL_W   = 4;
  localparam int CELL_BW = 3;
  localparam int CNT_W   = 5;

  // Internal widths, fixed by the field widths above
  localparam int CELL_W = 9;   // row * column_count + column <= 480
  localparam int BIT_W  = 11;  // cell * 3 <= 1440
  localparam int POS_W  = 8;   // byte position
  localparam int DIM_W  = 9;   // holds a dimension up to 256
  localparam int TOT_W  = 17;  // holds a cell total up to 65536

  localparam logic [CELL_BW-1:0] CELL_MASK      = 3'h7;
  localparam logic [2:0]         STRADDLE_SHIFT = 3'd5;  // 8 - cell bits

  // Config register map
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMN_COUNT = 2'd0,
    REG_ROW_COUNT    = 2'd1
  } cfg_reg_e;

  localparam logic [CNT_W-1:0] COLUMN_COUNT_RST = 5'd16;
  localparam logic [CNT_W-1:0] ROW_COUNT_RST    = 5'd16;

endpackage

[src/pcs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing beyond its parameters.
module pcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/packed_3bit_cell_store_top.sv]
// Packed 3-bit cell store: top level with byte banks, valid bits and control.
// Depends on pcs_pkg and pcs_ram.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one access: mode_i
//   (0 read, 1 write), row_i, column_i and write_value_i. Output channel
//   (out_valid_o / out_stall_i) returns one result per access: read_value_o
//   and out_of_range_o. A transfer happens when valid is high and stall low.
//   Each access has a transfer cycle, which computes the cell's byte
//   position and reads both candidate bytes, and a modify cycle, which
//   merges and writes back. The result enters the output register at the
//   end of the modify cycle. A new access is taken only in the idle state,
//   after the read-modify-write on the byte banks has completed.
//   Bytes are split into an even and an odd bank so a straddling cell's two
//   bytes come from one read. Per-entry valid bits, cleared at reset, make
//   the store read as all zero after reset with no clearing pass; config
//   registers reset to 16 columns and 16 rows.
//   A stalled result stays in the output register; the next access is taken
//   only once that register is empty or being drained.
//   cfg_valid_i / cfg_ready_o writes column_count (index 0) or row_count
//   (index 1); other indexes are ignored. Write config only while idle.
module packed_3bit_cell_store_top
  import pcs_pkg::*;
#(
  parameter int MAX_ROWS = pcs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = pcs_pkg::DEF_MAX_COLS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcs_pkg::CNT_W-1:0]      cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic [pcs_pkg::ROW_W-1:0]      row_i,
  input  logic [pcs_pkg::COL_W-1:0]      column_i,
  input  logic [pcs_pkg::CELL_BW-1:0]    write_value_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pcs_pkg::CELL_BW-1:0]    read_value_o,
  output logic                           out_of_range_o
);

  localparam int TOTAL_CELLS = MAX_ROWS * MAX_COLS;
  localparam int STORE_BYTES = (TOTAL_CELLS * CELL_BW + 7) / 8;
  // one spare entry per bank so the byte after the last one is addressable
  localparam int BANK_DEPTH  = STORE_BYTES / 2 + 1;
  localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  localparam logic [DIM_W-1:0] MAX_ROWS_L = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] MAX_COLS_L = DIM_W'(MAX_COLS);
  localparam logic [TOT_W-1:0] TOTAL_L    = TOT_W'(TOTAL_CELLS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_MOD  = 2'b10
  } state_e;

  state_e state_q, state_d;

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] column_count_q, row_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= COLUMN_COUNT_RST;
      row_count_q    <= ROW_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_COLUMN_COUNT: column_count_q <= cfg_data_i;
        REG_ROW_COUNT:    row_count_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  logic out_valid_q;
  logic in_xfer;

  // take a new access only when the result register will be free for it
  assign in_stall_o = !((state_q == S_IDLE) && (!out_valid_q || !out_stall_i));
  assign in_xfer    = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------
  // Address calculation (transfer cycle)
  // ---------------------------------------------------------------------
  logic [CELL_W-1:0]  cell_lin;
  logic [BIT_W-1:0]   bit_idx;
  logic [POS_W-1:0]   pos;
  logic               bad;
  logic [BANK_AW-1:0] even_ra, odd_ra;

  assign cell_lin = CELL_W'({5'd0, row_i} * {4'd0, column_count_q})
                  + CELL_W'({5'd0, column_i});

  assign bad = ({1'b0, row_i} >= row_count_q)
            || ({1'b0, column_i} >= column_count_q)
            || ({{(DIM_W-ROW_W){1'b0}}, row_i} >= MAX_ROWS_L)
            || ({{(DIM_W-COL_W){1'b0}}, column_i} >= MAX_COLS_L)
            || ({{(TOT_W-CELL_W){1'b0}}, cell_lin} >= TOTAL_L);

  assign bit_idx = ({2'b00, cell_lin} << 1) + {2'b00, cell_lin};
  assign pos     = bit_idx[BIT_W-1:3];

  // even bank holds bytes 0,2,4..; odd bank 1,3,5..
  // an odd position takes its upper byte from the next even entry
  assign even_ra = BANK_AW'({1'b0, pos[POS_W-1:1]} + {{(POS_W-1){1'b0}}, pos[0]});
  assign odd_ra  = BANK_AW'(pos[POS_W-1:1]);

  // ---------------------------------------------------------------------
  // Access registers
  // ---------------------------------------------------------------------
  logic               mode_q, bad_q, pos0_q;
  logic [2:0]         shift_q;
  logic [CELL_BW-1:0] wval_q;
  logic [BANK_AW-1:0] even_a_q, odd_a_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q   <= mode_i;
      bad_q    <= bad;
      pos0_q   <= pos[0];
      shift_q  <= bit_idx[2:0];
      wval_q   <= write_value_i;
      even_a_q <= even_ra;
      odd_a_q  <= odd_ra;
    end
  end

  // ---------------------------------------------------------------------
  // Byte banks and valid bits
  // ---------------------------------------------------------------------
  logic [BANK_DEPTH-1:0] even_vld_q, odd_vld_q;
  logic                  even_vrd_q, odd_vrd_q;
  logic [7:0]            even_rd, odd_rd;
  logic                  even_we, odd_we;
  logic [7:0]            even_wd, odd_wd;

  pcs_ram #(
    .WIDTH (8),
    .DEPTH (BANK_DEPTH),
    .AW    (BANK_AW)
  ) u_even_bank (
    .clk_i   (clk_i),
    .we_i    (even_we),
    .waddr_i (even_a_q),
    .wdata_i (even_wd),
    .raddr_i (even_ra),
    .rdata_o (even_rd)
  );

  pcs_ram #(
    .WIDTH (8),
    .DEPTH (BANK_DEPTH),
    .AW    (BANK_AW)
  ) u_odd_bank (
    .clk_i   (clk_i),
    .we_i    (odd_we),
    .waddr_i (odd_a_q),
    .wdata_i (odd_wd),
    .raddr_i (odd_ra),
    .rdata_o (odd_rd)
  );

  // sample valid bits alongside the RAM read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      even_vrd_q <= 1'b0;
      odd_vrd_q  <= 1'b0;
    end else if (in_xfer) begin
      even_vrd_q <= bad ? 1'b0 : even_vld_q[even_ra];
      odd_vrd_q  <= bad ? 1'b0 : odd_vld_q[odd_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      even_vld_q <= '0;
      odd_vld_q  <= '0;
    end else begin
      if (even_we) even_vld_q[even_a_q] <= 1'b1;
      if (odd_we)  odd_vld_q[odd_a_q]   <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Merge and write back (modify cycle)
  // ---------------------------------------------------------------------
  logic [7:0]  even_b, odd_b, lo_b, hi_b;
  logic [15:0] window, cmask, new_win;
  logic        do_write, straddle;
  logic [CELL_BW-1:0] rd_val;

  assign even_b = even_vrd_q ? even_rd : 8'h00;
  assign odd_b  = odd_vrd_q  ? odd_rd  : 8'h00;
  assign lo_b   = pos0_q ? odd_b  : even_b;
  assign hi_b   = pos0_q ? even_b : odd_b;
  assign window = {hi_b, lo_b};

  assign cmask    = {13'd0, CELL_MASK} << shift_q;
  assign new_win  = (window & ~cmask) | ({13'd0, wval_q} << shift_q);
  assign rd_val   = CELL_BW'(window >> shift_q);
  assign straddle = shift_q > STRADDLE_SHIFT;
  assign do_write = (state_q == S_MOD) && mode_q && !bad_q;

  // low byte goes to its own bank, high byte to the other only on straddle
  always_comb begin
    even_we = 1'b0;
    odd_we  = 1'b0;
    even_wd = new_win[7:0];
    odd_wd  = new_win[7:0];
    if (do_write) begin
      if (pos0_q) begin
        odd_we  = 1'b1;
        odd_wd  = new_win[7:0];
        even_we = straddle;
        even_wd = new_win[15:8];
      end else begin
        even_we = 1'b1;
        even_wd = new_win[7:0];
        odd_we  = straddle;
        odd_wd  = new_win[15:8];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_xfer) state_d = S_MOD;
      S_MOD:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic               out_valid_d;
  logic [CELL_BW-1:0] read_value_q;
  logic               oor_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (state_q == S_MOD) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MOD) begin
      read_value_q <= (mode_q || bad_q) ? '0 : rd_val;
      oor_q        <= bad_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_value_o   = read_value_q;
  assign out_of_range_o = oor_q;

endmodule
